### rtl/wrrsp_pkg.sv
`timescale 1ns / 1ps

package wrrsp_pkg;

    // defaults for the top level parameters
    localparam int MAX_CONNECTIONS_DEF = 8;
    localparam int WEIGHT_BITS_DEF     = 8;

    // fixed field widths of the word and the result
    localparam int ACTION_W     = 2;
    localparam int MASK_W       = 8;
    localparam int WINDOW_W     = 16;
    localparam int TARGET_W     = 3;
    localparam int NEW_WEIGHT_W = 8;
    localparam int CHOSEN_W     = 3;
    localparam int ACTIVE_W     = 4;
    localparam int COUNT_W      = 16;

    // configuration register indexes (paddr[2])
    localparam logic REG_PICK_MODE = 1'b0;
    localparam logic REG_ACTIVE    = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PICK       = 2'd0,
        ACT_SET_WEIGHT = 2'd1,
        ACT_ALL_ONE    = 2'd2,
        ACT_RELOAD     = 2'd3
    } action_t;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SETW,
        OP_CLR_IDX,
        OP_WONE,
        OP_RELOAD_STEP,
        OP_SUM_STEP,
        OP_SET_CSUM,
        OP_IDX_OWNER,
        OP_MUL,
        OP_DIV_START,
        OP_KEEP,
        OP_WALK_INIT,
        OP_VISIT,
        OP_FINE_END,
        OP_DONE
    } op_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_IF,
        J_DISPATCH,
        J_WAIT_IN,
        J_WAIT_OUT
    } jmp_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_IDX_MORE,
        C_OWNER_NONE,
        C_DIV_BUSY,
        C_KEEP,
        C_CSUM_NZ,
        C_VISIT_MORE
    } cond_t;

    typedef struct packed {
        op_t   op;
        jmp_t  jmp;
        cond_t cond;
        pc_t   target;
    } uword_t;

    // program labels
    localparam pc_t P_IDLE     = 5'd0;
    localparam pc_t P_DISP     = 5'd1;
    localparam pc_t P_SETW     = 5'd2;
    localparam pc_t P_ALL1     = 5'd3;
    localparam pc_t P_ALL1_LP  = 5'd4;
    localparam pc_t P_ALL1_END = 5'd5;
    localparam pc_t P_RLD      = 5'd6;
    localparam pc_t P_RLD_LP   = 5'd7;
    localparam pc_t P_RLD_END  = 5'd8;
    localparam pc_t P_COARSE   = 5'd9;
    localparam pc_t P_SUM      = 5'd10;
    localparam pc_t P_SUM_LP   = 5'd11;
    localparam pc_t P_OWNER    = 5'd12;
    localparam pc_t P_MUL      = 5'd13;
    localparam pc_t P_DIV      = 5'd14;
    localparam pc_t P_DIV_WAIT = 5'd15;
    localparam pc_t P_KEEP     = 5'd16;
    localparam pc_t P_FINE     = 5'd17;
    localparam pc_t P_FRLD     = 5'd18;
    localparam pc_t P_FRLD_LP  = 5'd19;
    localparam pc_t P_FRLD_END = 5'd20;
    localparam pc_t P_WALK     = 5'd21;
    localparam pc_t P_VISIT    = 5'd22;
    localparam pc_t P_FEND     = 5'd23;
    localparam pc_t P_DONE     = 5'd24;

    function automatic uword_t mk(input op_t op, input jmp_t jmp, input cond_t cond,
                                  input pc_t target);
        uword_t w;
        w.op     = op;
        w.jmp    = jmp;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    function automatic uword_t ucode_rom(input pc_t pc);
        uword_t w;
        unique case (pc)
            P_IDLE:     w = mk(OP_LOAD,        J_WAIT_IN,  C_NONE,       P_IDLE);
            P_DISP:     w = mk(OP_NOP,         J_DISPATCH, C_NONE,       P_IDLE);
            P_SETW:     w = mk(OP_SETW,        J_GOTO,     C_NONE,       P_DONE);
            P_ALL1:     w = mk(OP_CLR_IDX,     J_NEXT,     C_NONE,       P_IDLE);
            P_ALL1_LP:  w = mk(OP_WONE,        J_IF,       C_IDX_MORE,   P_ALL1_LP);
            P_ALL1_END: w = mk(OP_NOP,         J_GOTO,     C_NONE,       P_DONE);
            P_RLD:      w = mk(OP_CLR_IDX,     J_NEXT,     C_NONE,       P_IDLE);
            P_RLD_LP:   w = mk(OP_RELOAD_STEP, J_IF,       C_IDX_MORE,   P_RLD_LP);
            P_RLD_END:  w = mk(OP_SET_CSUM,    J_GOTO,     C_NONE,       P_DONE);
            P_COARSE:   w = mk(OP_NOP,         J_IF,       C_OWNER_NONE, P_FINE);
            P_SUM:      w = mk(OP_CLR_IDX,     J_NEXT,     C_NONE,       P_IDLE);
            P_SUM_LP:   w = mk(OP_SUM_STEP,    J_IF,       C_IDX_MORE,   P_SUM_LP);
            P_OWNER:    w = mk(OP_IDX_OWNER,   J_NEXT,     C_NONE,       P_IDLE);
            P_MUL:      w = mk(OP_MUL,         J_NEXT,     C_NONE,       P_IDLE);
            P_DIV:      w = mk(OP_DIV_START,   J_NEXT,     C_NONE,       P_IDLE);
            P_DIV_WAIT: w = mk(OP_NOP,         J_IF,       C_DIV_BUSY,   P_DIV_WAIT);
            P_KEEP:     w = mk(OP_KEEP,        J_IF,       C_KEEP,       P_DONE);
            P_FINE:     w = mk(OP_NOP,         J_IF,       C_CSUM_NZ,    P_WALK);
            P_FRLD:     w = mk(OP_CLR_IDX,     J_NEXT,     C_NONE,       P_IDLE);
            P_FRLD_LP:  w = mk(OP_RELOAD_STEP, J_IF,       C_IDX_MORE,   P_FRLD_LP);
            P_FRLD_END: w = mk(OP_SET_CSUM,    J_NEXT,     C_NONE,       P_IDLE);
            P_WALK:     w = mk(OP_WALK_INIT,   J_NEXT,     C_NONE,       P_IDLE);
            P_VISIT:    w = mk(OP_VISIT,       J_IF,       C_VISIT_MORE, P_VISIT);
            P_FEND:     w = mk(OP_FINE_END,    J_NEXT,     C_NONE,       P_IDLE);
            P_DONE:     w = mk(OP_DONE,        J_WAIT_OUT, C_NONE,       P_IDLE);
            default:    w = mk(OP_NOP,         J_GOTO,     C_NONE,       P_IDLE);
        endcase
        return w;
    endfunction

endpackage

### rtl/weighted_round_robin_sender_picker_unit.sv
`timescale 1ns / 1ps

// channel | handshake                 | payload
// --------+---------------------------+------------------------------------------------
// req     | req_valid / req_ready     | action, pending_mask, send_window,
//         |                           | target_connection, new_weight
// rsp     | rsp_valid / rsp_ready     | granted, chosen_connection
// apb     | psel penable pwrite pready| paddr, pwdata, prdata (0: pick_mode, 4: active)
//
// One word at a time, run by a microcode program (step counter + ROM).
// Set weight writes one entry; set-all / reload walk all connections; fine pick visits
// up to N, plus a reload pass when credits are out; coarse pick with no owner goes to fine
// pick, else sums weights, multiplies and divides, then grants the kept owner or picks fine.
// Reset: weights 1, credits 0, cursor at the last active connection; no clearing pass.
// A finished result sits in the rsp register; the next word is taken meanwhile and only
// the DONE step waits for that register to free up.
module weighted_round_robin_sender_picker_unit import wrrsp_pkg::*;
#(
    parameter int MAX_CONNECTIONS = MAX_CONNECTIONS_DEF,
    parameter int WEIGHT_BITS     = WEIGHT_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic [ACTION_W-1:0]     action,
    input  logic [MASK_W-1:0]       pending_mask,
    input  logic [WINDOW_W-1:0]     send_window,
    input  logic [TARGET_W-1:0]     target_connection,
    input  logic [NEW_WEIGHT_W-1:0] new_weight,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic                    granted,
    output logic [CHOSEN_W-1:0]     chosen_connection,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int IDX_W   = $clog2(MAX_CONNECTIONS);
    localparam int NW      = $clog2(MAX_CONNECTIONS + 1);
    localparam int SUM_W   = WEIGHT_BITS + IDX_W;
    localparam int PROD_W  = WINDOW_W + WEIGHT_BITS;
    localparam int CMP_W   = ((NW > ACTIVE_W) ? NW : ACTIVE_W) + 1;
    localparam int RESET_N = (MAX_CONNECTIONS < 8) ? MAX_CONNECTIONS : 8;
    localparam logic [IDX_W-1:0] RESET_CURSOR = IDX_W'(RESET_N - 1);

    // sequencer
    pc_t    pc_reg, pc_next;
    uword_t uop;
    logic   cond_true;

    // configuration
    logic                mode_reg;
    logic [ACTIVE_W-1:0] active_reg;

    // captured word
    action_t               action_reg;
    logic [MASK_W-1:0]     mask_reg, mask_next;
    logic [WINDOW_W-1:0]   window_reg, window_next;
    logic [TARGET_W-1:0]   target_reg, target_next;
    logic [WEIGHT_BITS-1:0] wt_reg, wt_next;
    action_t               action_next;

    // tables and scheduler state
    logic [WEIGHT_BITS-1:0] weight_reg [MAX_CONNECTIONS];
    logic [WEIGHT_BITS-1:0] weight_next [MAX_CONNECTIONS];
    logic [WEIGHT_BITS-1:0] credit_reg [MAX_CONNECTIONS];
    logic [WEIGHT_BITS-1:0] credit_next [MAX_CONNECTIONS];
    logic [SUM_W-1:0]       csum_reg, csum_next;
    logic [IDX_W-1:0]       cursor_reg, cursor_next;
    logic                   owner_valid_reg, owner_valid_next;
    logic [IDX_W-1:0]       owner_reg, owner_next;
    logic [COUNT_W-1:0]     consec_reg, consec_next;

    // datapath scratch
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              grant_reg, grant_next;
    logic [IDX_W-1:0]  who_reg, who_next;

    // result register
    logic                rsp_valid_reg, rsp_valid_next;
    logic                granted_reg, granted_next;
    logic [CHOSEN_W-1:0] chosen_reg, chosen_next;

    // helpers
    logic                   req_fire;
    logic                   out_free;
    logic [CMP_W-1:0]       act_ext;
    logic [CMP_W-1:0]       n_cmp;
    logic [MAX_CONNECTIONS-1:0] pend_vec;
    logic [CMP_W-1:0]       cur_inc;
    logic [IDX_W-1:0]       cur;
    logic                   had_credit;
    logic                   visit_more;
    logic [WEIGHT_BITS-1:0] wt_idx;
    logic                   idx_in_rot;
    logic                   idx_more;
    logic [PROD_W-1:0]      lim;
    logic                   keep;
    logic                   div_start;
    logic                   div_busy;
    logic [PROD_W-1:0]      div_quo;

    assign uop       = ucode_rom(pc_reg);
    assign req_ready = (uop.jmp == J_WAIT_IN);
    assign req_fire  = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign div_start = (uop.op == OP_DIV_START);
    assign pready    = 1'b1;

    wrrsp_div #(
        .DIVIDEND_W (PROD_W),
        .DIVISOR_W  (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (acc_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // active count clamped to 1..MAX_CONNECTIONS
    always_comb
    begin
        act_ext = CMP_W'(active_reg);
        if (act_ext == '0)
        begin
            n_cmp = CMP_W'(1);
        end
        else if (act_ext > CMP_W'(MAX_CONNECTIONS))
        begin
            n_cmp = CMP_W'(MAX_CONNECTIONS);
        end
        else
        begin
            n_cmp = act_ext;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_CONNECTIONS; i++)
        begin
            pend_vec[i] = (i < MASK_W) ? mask_reg[3'(i)] : 1'b0;
        end
    end

    always_comb
    begin
        cur_inc    = CMP_W'(cursor_reg) + CMP_W'(1);
        cur        = (cur_inc >= n_cmp) ? '0 : IDX_W'(cur_inc);
        had_credit = credit_reg[cur] != '0;
        visit_more = !((pend_vec[cur] && had_credit) ||
                       (CMP_W'(cnt_reg) + CMP_W'(1) >= n_cmp));
        wt_idx     = weight_reg[idx_reg];
        idx_in_rot = CMP_W'(idx_reg) < n_cmp;
        idx_more   = idx_reg != IDX_W'(MAX_CONNECTIONS - 1);
        // zero weight sum gives a zero block length
        lim        = (acc_reg == '0) ? '0 : div_quo;
        keep       = (PROD_W'(consec_reg) < lim) && pend_vec[owner_reg];
    end

    always_comb
    begin
        case (uop.cond)
            C_IDX_MORE:   cond_true = idx_more;
            C_OWNER_NONE: cond_true = !owner_valid_reg;
            C_DIV_BUSY:   cond_true = div_busy;
            C_KEEP:       cond_true = keep;
            C_CSUM_NZ:    cond_true = csum_reg != '0;
            C_VISIT_MORE: cond_true = visit_more;
            default:      cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (uop.jmp)
            J_NEXT:     pc_next = pc_reg + pc_t'(1);
            J_GOTO:     pc_next = uop.target;
            J_IF:       pc_next = cond_true ? uop.target : pc_reg + pc_t'(1);
            J_WAIT_IN:  pc_next = req_fire ? pc_reg + pc_t'(1) : pc_reg;
            J_WAIT_OUT: pc_next = out_free ? uop.target : pc_reg;
            J_DISPATCH:
            begin
                unique case (action_reg)
                    ACT_SET_WEIGHT: pc_next = P_SETW;
                    ACT_ALL_ONE:    pc_next = P_ALL1;
                    ACT_RELOAD:     pc_next = P_RLD;
                    ACT_PICK:       pc_next = mode_reg ? P_COARSE : P_FINE;
                    default:        pc_next = P_FINE;
                endcase
            end
            default:    pc_next = P_IDLE;
        endcase
    end

    // datapath driven by the control word
    always_comb
    begin
        action_next      = action_reg;
        mask_next        = mask_reg;
        window_next      = window_reg;
        target_next      = target_reg;
        wt_next          = wt_reg;
        weight_next      = weight_reg;
        credit_next      = credit_reg;
        csum_next        = csum_reg;
        cursor_next      = cursor_reg;
        owner_valid_next = owner_valid_reg;
        owner_next       = owner_reg;
        consec_next      = consec_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        acc_next         = acc_reg;
        prod_next        = prod_reg;
        grant_next       = grant_reg;
        who_next         = who_reg;
        granted_next     = granted_reg;
        chosen_next      = chosen_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;

        unique case (uop.op)
            OP_LOAD:
            begin
                if (req_fire)
                begin
                    action_next = action_t'(action);
                    mask_next   = pending_mask;
                    window_next = send_window;
                    target_next = target_connection;
                    wt_next     = WEIGHT_BITS'(new_weight);
                    grant_next  = 1'b0;
                    who_next    = '0;
                end
            end
            OP_SETW:
            begin
                if (int'(target_reg) < MAX_CONNECTIONS)
                begin
                    weight_next[IDX_W'(target_reg)] = wt_reg;
                end
            end
            OP_CLR_IDX:
            begin
                idx_next = '0;
                acc_next = '0;
            end
            OP_WONE:
            begin
                weight_next[idx_reg] = WEIGHT_BITS'(1);
                idx_next = idx_reg + IDX_W'(1);
            end
            OP_RELOAD_STEP:
            begin
                credit_next[idx_reg] = wt_idx;
                if (idx_in_rot)
                begin
                    acc_next = acc_reg + SUM_W'(wt_idx);
                end
                idx_next = idx_reg + IDX_W'(1);
            end
            OP_SUM_STEP:
            begin
                if (idx_in_rot)
                begin
                    acc_next = acc_reg + SUM_W'(wt_idx);
                end
                idx_next = idx_reg + IDX_W'(1);
            end
            OP_SET_CSUM:
            begin
                csum_next = acc_reg;
            end
            OP_IDX_OWNER:
            begin
                idx_next = owner_reg;
            end
            OP_MUL:
            begin
                prod_next = PROD_W'(window_reg) * PROD_W'(wt_idx);
            end
            OP_KEEP:
            begin
                if (consec_reg != '1)
                begin
                    consec_next = consec_reg + COUNT_W'(1);
                end
                if (keep)
                begin
                    grant_next = 1'b1;
                    who_next   = owner_reg;
                end
            end
            OP_WALK_INIT:
            begin
                cnt_next = '0;
            end
            OP_VISIT:
            begin
                cursor_next = cur;
                who_next    = cur;
                cnt_next    = cnt_reg + NW'(1);
                if (had_credit)
                begin
                    credit_next[cur] = credit_reg[cur] - WEIGHT_BITS'(1);
                    if (csum_reg != '0)
                    begin
                        csum_next = csum_reg - SUM_W'(1);
                    end
                end
            end
            OP_FINE_END:
            begin
                grant_next = pend_vec[who_reg];
                if (mode_reg)
                begin
                    owner_valid_next = pend_vec[who_reg];
                    if (pend_vec[who_reg])
                    begin
                        owner_next  = who_reg;
                        consec_next = COUNT_W'(1);
                    end
                    else
                    begin
                        consec_next = '0;
                    end
                end
            end
            OP_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    granted_next   = grant_reg;
                    chosen_next    = grant_reg ? CHOSEN_W'(who_reg) : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg          <= P_IDLE;
            mode_reg        <= 1'b0;
            active_reg      <= ACTIVE_W'(8);
            csum_reg        <= '0;
            cursor_reg      <= RESET_CURSOR;
            owner_valid_reg <= 1'b0;
            owner_reg       <= '0;
            consec_reg      <= '0;
            rsp_valid_reg   <= 1'b0;
            for (int i = 0; i < MAX_CONNECTIONS; i++)
            begin
                weight_reg[i] <= WEIGHT_BITS'(1);
                credit_reg[i] <= '0;
            end
        end
        else
        begin
            pc_reg          <= pc_next;
            csum_reg        <= csum_next;
            cursor_reg      <= cursor_next;
            owner_valid_reg <= owner_valid_next;
            owner_reg       <= owner_next;
            consec_reg      <= consec_next;
            rsp_valid_reg   <= rsp_valid_next;
            weight_reg      <= weight_next;
            credit_reg      <= credit_next;
            if (psel && penable && pwrite)
            begin
                unique case (paddr[2])
                    REG_PICK_MODE: mode_reg   <= pwdata[0];
                    REG_ACTIVE:    active_reg <= pwdata[ACTIVE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        mask_reg    <= mask_next;
        window_reg  <= window_next;
        target_reg  <= target_next;
        wt_reg      <= wt_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        grant_reg   <= grant_next;
        who_reg     <= who_next;
        granted_reg <= granted_next;
        chosen_reg  <= chosen_next;
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_PICK_MODE: prdata = {31'b0, mode_reg};
            REG_ACTIVE:    prdata = {{(32 - ACTIVE_W){1'b0}}, active_reg};
            default:       prdata = '0;
        endcase
    end

    assign rsp_valid         = rsp_valid_reg;
    assign granted           = granted_reg;
    assign chosen_connection = chosen_reg;

`ifndef ASSERT_OFF
    a_div_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (pc_reg == P_DIV_WAIT))
        else $error("divider busy outside its wait step");

    a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (uop.op == OP_DIV_START) |=> div_busy)
        else $error("divider did not start");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (uop.op == OP_DONE && rsp_valid_reg && !rsp_ready) |=> (pc_reg == P_DONE))
        else $error("result step left while rsp register still full");

    a_visit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (uop.op == OP_VISIT) |-> (CMP_W'(cnt_reg) < n_cmp))
        else $error("rotation walk visited more than the active connections");
`endif

endmodule

### rtl/wrrsp_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module wrrsp_div import wrrsp_pkg::*;
#(
    parameter int DIVIDEND_W = WINDOW_W + WEIGHT_BITS_DEF,
    parameter int DIVISOR_W  = WEIGHT_BITS_DEF + 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};

        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
